// File: hw/rtl/ric4_pkg.sv
`timescale 1ns / 1ps
// Package: beat types, fixed-point constants and microcode ROM for the 4x4 rigid inverse/compose.
package ric4_pkg;

    localparam int ELEM_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int IDX_W     = 4;
    localparam int PROD_W    = 2 * ELEM_W - FRAC_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int NUM_STEPS = 62;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
    // 1.0 clamps to the largest positive value when it has no room
    localparam logic [ELEM_W-1:0] ELEM_ONE =
        (FRAC_W >= ELEM_W - 1) ? ELEM_MAX : ELEM_W'(64'd1 << FRAC_W);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;
    localparam logic SEL_CUR   = 1'b0;
    localparam logic SEL_PREV  = 1'b1;

    typedef struct packed {
        logic                     func;
        logic                     which_matrix;
        logic [IDX_W-1:0]         element_index;
        logic signed [ELEM_W-1:0] element_value;
    } ric_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic signed [ELEM_W-1:0] out_value;
        logic                     saturated;
        logic                     last_result;
    } ric_res_t;

    typedef enum logic [1:0] {
        B_CUR,
        B_TREG,
        B_ONE
    } bsrc_t;

    typedef enum logic {
        DST_T,
        DST_OUT
    } dst_t;

    typedef enum logic {
        SEQ_NEXT,
        SEQ_END
    } seq_t;

    typedef struct packed {
        logic             mac;
        logic             a_prev;
        logic [IDX_W-1:0] a_addr;
        bsrc_t            b_src;
        logic [IDX_W-1:0] b_addr;
        logic             first;
        logic             last;
        dst_t             dst;
        logic [IDX_W-1:0] dst_idx;
        seq_t             seq;
    } uword_t;

    typedef uword_t [NUM_STEPS-1:0] urom_t;

    // step 0: idle; then 9 translation MACs; then 16 result elements
    function automatic urom_t build_urom();
        urom_t rom;
        int    s;
        int    nk;
        rom = '0;
        s   = 1;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                rom[s].mac     = 1'b1;
                rom[s].a_prev  = 1'b0;
                rom[s].a_addr  = IDX_W'(r * 4 + k);
                rom[s].b_src   = B_CUR;
                rom[s].b_addr  = IDX_W'(12 + k);
                rom[s].first   = (k == 0);
                rom[s].last    = (k == 2);
                rom[s].dst     = DST_T;
                rom[s].dst_idx = IDX_W'(r);
                rom[s].seq     = SEQ_NEXT;
                s++;
            end
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                nk = (c == 3) ? 4 : 3;
                for (int k = 0; k < nk; k++) begin
                    rom[s].mac    = 1'b1;
                    rom[s].a_prev = 1'b1;
                    rom[s].a_addr = IDX_W'(k * 4 + r);
                    if (c < 3) begin
                        rom[s].b_src  = B_CUR;
                        rom[s].b_addr = IDX_W'(k * 4 + c);
                    end
                    else if (k < 3) begin
                        rom[s].b_src  = B_TREG;
                        rom[s].b_addr = IDX_W'(k);
                    end
                    else begin
                        rom[s].b_src  = B_ONE;
                        rom[s].b_addr = '0;
                    end
                    rom[s].first   = (k == 0);
                    rom[s].last    = (k == nk - 1);
                    rom[s].dst     = DST_OUT;
                    rom[s].dst_idx = IDX_W'(c * 4 + r);
                    rom[s].seq     = SEQ_NEXT;
                    s++;
                end
            end
        end
        rom[NUM_STEPS-1].seq = SEQ_END;
        return rom;
    endfunction

    localparam urom_t UROM = build_urom();

endpackage

// File: hw/rtl/rigid_inverse_compose_4x4.sv
`timescale 1ns / 1ps
// Top level: microcoded rigid-transform inverse and 4x4 compose with one shared MAC.
// Load beat: one per cycle while idle, no result.
// Run beat: 61 microcode steps, one product per cycle while results are not stalled, through
// the shared 32x32 MAC (read, multiply, accumulate, finalize); 16 results are produced,
// and a stalled result freezes the pipe. The next beat is accepted once the pipe drains.
// Reset: sequencer idle, both stores read as zero via per-entry valid bits.
module rigid_inverse_compose_4x4 (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  ric4_pkg::ric_req_t  req,
    output logic                res_valid,
    input  logic                res_stall,
    output ric4_pkg::ric_res_t  res
);
    import ric4_pkg::*;

    logic [ELEM_W-1:0] cur_mem  [16];
    logic [ELEM_W-1:0] prev_mem [16];
    logic [15:0]       cur_vld_reg;
    logic [15:0]       prev_vld_reg;

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    uword_t            uw;

    logic              load_acc;
    logic              run_acc;
    logic              advance;
    logic              issue;
    logic              busy;

    logic [ELEM_W-1:0] cur_a_reg;
    logic [ELEM_W-1:0] cur_b_reg;
    logic [ELEM_W-1:0] prev_rd_reg;

    logic              s1_vld_reg, s2_vld_reg, s3_vld_reg;
    uword_t            s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;

    logic signed [ELEM_W-1:0]   op_a;
    logic signed [ELEM_W-1:0]   op_b;
    logic signed [2*ELEM_W-1:0] prod_full;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    fin_val;
    logic [ELEM_W-1:0]          sat_val;
    logic                       fits;

    logic [ELEM_W-1:0] t_reg [3];
    logic              tclip_reg;
    logic              fin_t;
    logic              fin_out;

    logic              res_valid_reg;
    ric_res_t          res_reg;

    assign uw        = UROM[pc_reg];
    assign busy      = (pc_reg != '0) | s1_vld_reg | s2_vld_reg | s3_vld_reg;
    assign req_stall = busy;
    assign load_acc  = req_valid & ~req_stall & (req.func == FUNC_LOAD);
    assign run_acc   = req_valid & ~req_stall & (req.func == FUNC_RUN);
    assign advance   = ~(res_valid_reg & res_stall);
    assign issue     = advance & (pc_reg != '0) & uw.mac;

    always_comb
    begin
        pc_next = pc_reg;
        if (pc_reg == '0)
        begin
            if (run_acc)
                pc_next = STEP_W'(1);
        end
        else if (advance)
        begin
            pc_next = (uw.seq == SEQ_END) ? '0 : pc_reg + STEP_W'(1);
        end
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (load_acc)
        begin
            if (req.which_matrix == SEL_PREV)
                prev_mem[req.element_index] <= req.element_value;
            else
                cur_mem[req.element_index] <= req.element_value;
        end
        if (issue)
        begin
            cur_a_reg   <= cur_vld_reg[uw.a_addr] ? cur_mem[uw.a_addr] : '0;
            cur_b_reg   <= cur_vld_reg[uw.b_addr] ? cur_mem[uw.b_addr] : '0;
            prev_rd_reg <= prev_vld_reg[uw.a_addr] ? prev_mem[uw.a_addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_vld_reg  <= '0;
            prev_vld_reg <= '0;
        end
        else if (load_acc)
        begin
            if (req.which_matrix == SEL_PREV)
                prev_vld_reg[req.element_index] <= 1'b1;
            else
                cur_vld_reg[req.element_index] <= 1'b1;
        end
    end

    // multiply stage
    always_comb
    begin
        op_a = s1_ctl_reg.a_prev ? prev_rd_reg : cur_a_reg;
        case (s1_ctl_reg.b_src)
            B_CUR:   op_b = cur_b_reg;
            B_TREG:  op_b = t_reg[s1_ctl_reg.b_addr[1:0]];
            B_ONE:   op_b = ELEM_ONE;
            default: op_b = '0;
        endcase
        prod_full = op_a * op_b;
    end

    // finalize stage: negate for translation, saturate to element width
    always_comb
    begin
        fin_t   = s3_vld_reg & s3_ctl_reg.last & (s3_ctl_reg.dst == DST_T);
        fin_out = s3_vld_reg & s3_ctl_reg.last & (s3_ctl_reg.dst == DST_OUT);
        fin_val = (s3_ctl_reg.dst == DST_T) ? -acc_reg : acc_reg;
        fits    = (&fin_val[ACC_W-1:ELEM_W-1]) | ~(|fin_val[ACC_W-1:ELEM_W-1]);
        if (fits)
            sat_val = fin_val[ELEM_W-1:0];
        else
            sat_val = fin_val[ACC_W-1] ? ELEM_MIN : ELEM_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ctl_reg <= uw;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            prod_reg   <= prod_full[2*ELEM_W-1:FRAC_W];
            acc_reg    <= (s2_ctl_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);
            if (fin_t)
                t_reg[s3_ctl_reg.dst_idx[1:0]] <= sat_val;
            if (fin_out)
            begin
                res_reg.out_index   <= s3_ctl_reg.dst_idx;
                res_reg.out_value   <= sat_val;
                res_reg.saturated   <= ~fits | ((&s3_ctl_reg.dst_idx[3:2]) & tclip_reg);
                res_reg.last_result <= (s3_ctl_reg.dst_idx == IDX_W'(15));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            tclip_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (run_acc)
                tclip_reg <= 1'b0;
            else if (advance & fin_t & ~fits)
                tclip_reg <= 1'b1;
            if (advance)
            begin
                s1_vld_reg    <= issue;
                s2_vld_reg    <= s1_vld_reg;
                s3_vld_reg    <= s2_vld_reg;
                res_valid_reg <= fin_out;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: hw/rtl/ric4_chk.sv
`timescale 1ns / 1ps
// Port checker for rigid_inverse_compose_4x4 and its bind.
module ric4_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input ric4_pkg::ric_req_t req,
    input logic               res_valid,
    input logic               res_stall,
    input ric4_pkg::ric_res_t res
);
    import ric4_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result beat changed while stalled");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.last_result == (res.out_index == IDX_W'(15))))
        else $error("last_result not on final element");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.func |=> req_stall)
        else $error("input not stalled after run beat");

    a_no_load_during_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !res.last_result |-> req_stall)
        else $error("input open while results still pending");

endmodule

bind rigid_inverse_compose_4x4 ric4_chk u_ric4_chk (.*);
